FILE: design/bale_pkg.sv
// ----------------------------------------------------------------------------
// bale_pkg: shared types and constants of the bounded array list engine
// Field widths, command and status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bale_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;
	localparam int ADDR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	localparam int CMD_W  = 3;
	localparam int IDX_W  = 4;
	localparam int VAL_W  = 32;
	localparam int RDW_W  = 32;
	localparam int STAT_W = 2;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_POP    = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_ERASE  = 3'd3,
		CMD_READ   = 3'd4,
		CMD_WRITE  = 3'd5
	} cmd_e;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MOVE_UP,
		S_MOVE_DN,
		S_PUT,
		S_DONE
	} state_t;

	// read address relative to the pointer value after this cycle's update
	typedef enum logic [1:0] {
		RA_AT,
		RA_BELOW,
		RA_ABOVE
	} raddr_sel_t;

	typedef struct packed {
		logic       capture;
		logic       ptr_ld_cnt;
		logic       ptr_ld_idx;
		logic       ptr_dec;
		logic       ptr_inc;
		logic       re;
		raddr_sel_t ra;
		logic       we;
		logic       wsrc_val;
		logic       res_load;
		logic       res_rd;
		logic       cnt_inc;
		logic       cnt_dec;
	} ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		status_t          chk;
		logic             ins_direct;
		logic             ers_direct;
		logic             last_up;
		logic             last_dn;
		logic             rsp_free;
	} sts_t;

endpackage

FILE: design/bale_dpath.sv
// ----------------------------------------------------------------------------
// bale_dpath: datapath of the bounded array list engine
// Holds the captured transaction, the entry count, the move pointer, the
// entry memory and the result register.
// ----------------------------------------------------------------------------
module bale_dpath import bale_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	output sts_t              sts,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [IDX_W-1:0]  index,
	input  logic [VAL_W-1:0]  value,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [RDW_W-1:0]  read_word,
	output logic [CNT_BITS-1:0] count,
	output logic [STAT_W-1:0] status
);

	logic [CMD_W-1:0] cmd_q;
	logic [IDX_W-1:0] idx_q;
	word_t            val_q;
	cnt_t             count_q;
	addr_t            ptr_q;
	addr_t            ptr_d;
	addr_t            raddr;
	word_t            rdata_q;
	word_t            wdata;
	word_t            mem [DEPTH];
	cnt_t             idx_ext;
	cnt_t             count_d;
	status_t          chk;
	logic             full;
	logic             empty;

	logic              rsp_valid_q;
	logic [RDW_W-1:0]  rsp_word_q;
	cnt_t              rsp_count_q;
	status_t           rsp_status_q;

	// transaction capture
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= cmd;
			idx_q <= index;
			val_q <= value[WORD_BITS-1:0];
		end
	end

	// legality check against the current count
	assign idx_ext = CNT_BITS'(idx_q);
	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);

	always_comb begin
		chk = ST_OK;
		case (cmd_q)
			CMD_APPEND: chk = full ? ST_FULL : ST_OK;
			CMD_POP:    chk = empty ? ST_EMPTY : ST_OK;
			CMD_INSERT: begin
				if (full)
					chk = ST_FULL;
				else if (idx_ext > count_q)
					chk = ST_RANGE;
			end
			CMD_ERASE, CMD_READ, CMD_WRITE: begin
				if (empty)
					chk = ST_EMPTY;
				else if (idx_ext >= count_q)
					chk = ST_RANGE;
			end
			default: chk = ST_OK;
		endcase
	end

	// move pointer
	always_comb begin
		if (ctl.ptr_ld_cnt)
			ptr_d = ADDR_BITS'(count_q);
		else if (ctl.ptr_ld_idx)
			ptr_d = ADDR_BITS'(idx_q);
		else if (ctl.ptr_dec)
			ptr_d = ptr_q - ADDR_BITS'(1);
		else if (ctl.ptr_inc)
			ptr_d = ptr_q + ADDR_BITS'(1);
		else
			ptr_d = ptr_q;
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
	end

	always_comb begin
		case (ctl.ra)
			RA_AT:    raddr = ptr_d;
			RA_BELOW: raddr = ptr_d - ADDR_BITS'(1);
			RA_ABOVE: raddr = ptr_d + ADDR_BITS'(1);
			default:  raddr = ptr_d;
		endcase
	end

	// entry memory: one write port, one registered read port
	assign wdata = ctl.wsrc_val ? val_q : rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.we)
			mem[ptr_q] <= wdata;
		if (ctl.re)
			rdata_q <= mem[raddr];
	end

	// count update together with the result
	always_comb begin
		count_d = count_q;
		if (ctl.res_load && ctl.cnt_inc)
			count_d = count_q + CNT_BITS'(1);
		else if (ctl.res_load && ctl.cnt_dec)
			count_d = count_q - CNT_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else
			count_q <= count_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (ctl.res_load)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			rsp_word_q   <= ctl.res_rd ? RDW_W'(rdata_q) : '0;
			rsp_count_q  <= count_d;
			rsp_status_q <= chk;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign read_word = rsp_word_q;
	assign count     = rsp_count_q;
	assign status    = rsp_status_q;

	// status toward the controller
	always_comb begin
		sts.cmd        = cmd_q;
		sts.chk        = chk;
		sts.ins_direct = (idx_ext == count_q);
		sts.ers_direct = ((idx_ext + CNT_BITS'(1)) == count_q);
		sts.last_up    = ((ptr_q - ADDR_BITS'(1)) == ADDR_BITS'(idx_q));
		sts.last_dn    = ((CNT_BITS'(ptr_q) + CNT_BITS'(2)) == count_q);
		sts.rsp_free   = !rsp_valid_q || !rsp_stall;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("entry count above capacity");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.res_load |-> !(rsp_valid_q && rsp_stall))
		else $error("result loaded over a stalled result");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.res_load |=> $stable(count_q))
		else $error("count changed outside result load");

	a_word_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_word_q != '0) |-> (rsp_status_q == ST_OK))
		else $error("nonzero read word with error status");

endmodule

FILE: design/bale_ctrl.sv
// ----------------------------------------------------------------------------
// bale_ctrl: controller of the bounded array list engine
// Sequences check, entry moves, the final write and the result load.
// ----------------------------------------------------------------------------
module bale_ctrl import bale_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_d;
	logic   ok;

	assign ok = (sts.chk == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		ctl.ra    = RA_AT;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall   = 1'b0;
				ctl.capture = req_valid;
				if (req_valid)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				// load pointer and prefetch the first source entry
				ctl.re = 1'b1;
				if (sts.cmd inside {CMD_APPEND, CMD_INSERT})
					ctl.ptr_ld_cnt = 1'b1;
				else
					ctl.ptr_ld_idx = 1'b1;
				if (sts.cmd == CMD_INSERT)
					ctl.ra = RA_BELOW;
				else if (sts.cmd == CMD_ERASE)
					ctl.ra = RA_ABOVE;
				if (!ok) begin
					state_d = S_DONE;
				end else begin
					case (sts.cmd)
						CMD_APPEND: state_d = S_PUT;
						CMD_INSERT: state_d = sts.ins_direct ? S_PUT : S_MOVE_UP;
						CMD_ERASE:  state_d = sts.ers_direct ? S_DONE : S_MOVE_DN;
						CMD_WRITE:  state_d = S_PUT;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_MOVE_UP: begin
				ctl.we      = 1'b1;
				ctl.ptr_dec = 1'b1;
				ctl.re      = 1'b1;
				ctl.ra      = RA_BELOW;
				if (sts.last_up)
					state_d = S_PUT;
			end
			S_MOVE_DN: begin
				ctl.we      = 1'b1;
				ctl.ptr_inc = 1'b1;
				ctl.re      = 1'b1;
				ctl.ra      = RA_ABOVE;
				if (sts.last_dn)
					state_d = S_DONE;
			end
			S_PUT: begin
				ctl.we       = 1'b1;
				ctl.wsrc_val = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				ctl.res_load = sts.rsp_free;
				ctl.res_rd   = ok && (sts.cmd == CMD_READ);
				ctl.cnt_inc  = ok && (sts.cmd inside {CMD_APPEND, CMD_INSERT});
				ctl.cnt_dec  = ok && (sts.cmd inside {CMD_POP, CMD_ERASE});
				if (sts.rsp_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: design/bounded_array_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_array_list_engine: fixed-capacity ordered list of words
// Append, remove last, insert, erase, read and overwrite on a list of up to
// DEPTH entries; each transaction returns one result with word, count and
// status.
// ----------------------------------------------------------------------------
//
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------
// request  | req_valid / req_stall  | cmd[2:0] index[3:0] value[31:0]
// response | rsp_valid / rsp_stall  | read_word[31:0] count[4:0] status[1:0]
//
// Steps of a transaction, from acceptance to the next acceptance:
//   remove last, read, unused codes, refused commands: check, result load
//   append, overwrite: check, write of the value, result load
//   insert at i: check, move up of entries i..last, value write, result load
//   erase at i: check, move down of the entries above i, result load
// The entry memory has one write port and one registered read port, so one
// entry moves per cycle.
// Reset (arst_n low) empties the list at once; the entries themselves are
// not cleared. A request is taken while an earlier response still waits;
// a stalled response holds the next one in its final step.
// ----------------------------------------------------------------------------
module bounded_array_list_engine import bale_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [IDX_W-1:0]  index,
	input  logic [VAL_W-1:0]  value,
	// response channel
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [RDW_W-1:0]  read_word,
	output logic [CNT_BITS-1:0] count,
	output logic [STAT_W-1:0] status
);

	ctl_t ctl;
	sts_t sts;

	// sequencer: check, moves, final write, result load
	bale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// entry memory, count, pointer and result register
	bale_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd       (cmd),
		.index     (index),
		.value     (value),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.read_word (read_word),
		.count     (count),
		.status    (status)
	);

endmodule
